// File: design/ihm_pkg.sv
`timescale 1ns / 1ps
// ihm_pkg: shared types, constants and controller/datapath signal groups
package ihm_pkg;

    localparam int COORD_W       = 20;
    localparam int FVAL_W        = 32;
    localparam int TOL_W         = 21;
    localparam int STEP_W        = 6;
    localparam int FRAC_BITS     = 16;
    localparam int MAX_STEPS_DEF = 48;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [FVAL_W-1:0]  fval_t;
    typedef logic [TOL_W-1:0]          tol_t;
    typedef logic [STEP_W-1:0]         step_t;

    // which point the shared cubic unit works on
    typedef logic [1:0] sel_t;
    localparam sel_t SEL_X = 2'd0;
    localparam sel_t SEL_Y = 2'd1;
    localparam sel_t SEL_Z = 2'd2;

    typedef struct packed {
        logic load;
        logic mul_sq;
        logic mul_cu;
        logic store;
        logic update;
        logic out_load;
        sel_t sel;
    } ihm_cmd_t;

    typedef struct packed {
        logic more;
    } ihm_stat_t;

endpackage

// File: design/ihm_if.sv
`timescale 1ns / 1ps
// ihm_if: operand, result and configuration channel interfaces
interface ihm_in_if
    import ihm_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t left_end;
    coord_t right_end;

    modport source (output valid, output left_end, output right_end, input ready);
    modport sink (input valid, input left_end, input right_end, output ready);
endinterface

interface ihm_out_if
    import ihm_pkg::*;
();
    logic  valid;
    logic  ready;
    coord_t x_min;
    fval_t f_min;
    step_t steps_taken;
    logic  cap_reached;

    modport source (output valid, output x_min, output f_min, output steps_taken,
                    output cap_reached, input ready);
    modport sink (input valid, input x_min, input f_min, input steps_taken,
                  input cap_reached, output ready);
endinterface

interface ihm_cfg_if
    import ihm_pkg::*;
();
    logic valid;
    logic ready;
    tol_t tolerance;

    modport source (output valid, output tolerance, input ready);
    modport sink (input valid, input tolerance, output ready);
endinterface

// File: design/ihm_dp.sv
`timescale 1ns / 1ps
// ihm_dp: interval registers, shared cubic unit and result registers
module ihm_dp
    import ihm_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ihm_cmd_t  cmd,
    output ihm_stat_t stat,
    input  coord_t    left_end,
    input  coord_t    right_end,
    input  logic      cfg_valid,
    input  tol_t      cfg_tolerance,
    output coord_t    x_min,
    output fval_t     f_min,
    output step_t     steps_taken,
    output logic      cap_reached
);

    localparam int PROD_W = 44;
    localparam int SQ_W   = 24;
    localparam int SUM_W  = 34;

    tol_t   tol_reg;
    coord_t a_reg;
    coord_t b_reg;
    coord_t x_reg;
    fval_t  fx_reg;
    fval_t  fy_reg;
    fval_t  fz_reg;
    step_t  k_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SQ_W-1:0]   x2_reg;
    coord_t x_min_reg;
    fval_t  f_min_reg;
    step_t  steps_reg;
    logic   cap_reg;

    coord_t lo;
    coord_t hi;
    logic signed [COORD_W:0] mid_sum;
    logic signed [COORD_W:0] len_s;
    tol_t   len;
    tol_t   quarter;
    logic signed [COORD_W:0] y_s;
    logic signed [COORD_W:0] z_s;
    coord_t y_pt;
    coord_t z_pt;
    coord_t opnd;
    logic signed [SQ_W-1:0]   sq_shift;
    logic signed [SQ_W-1:0]   mul_a;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  x3_w;
    logic signed [SUM_W-1:0]  sum_w;
    fval_t  f_val;
    logic   len_gt_tol;

    always_comb
    begin
        if (left_end > right_end)
        begin
            lo = right_end;
            hi = left_end;
        end
        else
        begin
            lo = left_end;
            hi = right_end;
        end
        mid_sum = {lo[COORD_W-1], lo} + {hi[COORD_W-1], hi};
    end

    assign len_s      = {b_reg[COORD_W-1], b_reg} - {a_reg[COORD_W-1], a_reg};
    assign len        = TOL_W'(len_s);
    assign quarter    = len >> 2;
    assign y_s        = {a_reg[COORD_W-1], a_reg} + $signed({1'b0, quarter[COORD_W-1:0]});
    assign z_s        = {b_reg[COORD_W-1], b_reg} - $signed({1'b0, quarter[COORD_W-1:0]});
    assign y_pt       = y_s[COORD_W-1:0];
    assign z_pt       = z_s[COORD_W-1:0];
    assign len_gt_tol = len > tol_reg;
    assign stat.more  = len_gt_tol && (k_reg < STEP_W'(MAX_STEPS));

    always_comb
    begin
        unique case (cmd.sel)
            SEL_Y:   opnd = y_pt;
            SEL_Z:   opnd = z_pt;
            default: opnd = x_reg;
        endcase
    end

    // shared multiplier: square first, then square times operand
    assign sq_shift = SQ_W'(prod_reg >>> FRAC_BITS);
    assign mul_a    = cmd.mul_cu ? sq_shift : SQ_W'(opnd);
    assign prod     = mul_a * opnd;

    always_comb
    begin
        x3_w  = SUM_W'(prod_reg >>> FRAC_BITS);
        sum_w = x3_w + SUM_W'(x2_reg) + (SUM_W'(x2_reg) <<< 1)
                - (SUM_W'(2) <<< FRAC_BITS);
        if (sum_w > SUM_W'(32'sh7FFF_FFFF))
            f_val = 32'sh7FFF_FFFF;
        else if (sum_w < -SUM_W'(33'sh0_8000_0000))
            f_val = 32'sh8000_0000;
        else
            f_val = sum_w[FVAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_valid)
            tol_reg <= cfg_tolerance;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_sq || cmd.mul_cu)
            prod_reg <= prod;
        if (cmd.mul_cu)
            x2_reg <= sq_shift;
        if (cmd.load)
        begin
            a_reg <= lo;
            b_reg <= hi;
            x_reg <= mid_sum[COORD_W:1];
            k_reg <= '0;
        end
        else if (cmd.update)
        begin
            if (fy_reg < fx_reg)
            begin
                b_reg  <= x_reg;
                x_reg  <= y_pt;
                fx_reg <= fy_reg;
            end
            else if (fz_reg < fx_reg)
            begin
                a_reg  <= x_reg;
                x_reg  <= z_pt;
                fx_reg <= fz_reg;
            end
            else
            begin
                a_reg <= y_pt;
                b_reg <= z_pt;
            end
            k_reg <= k_reg + STEP_W'(1);
        end
        else if (cmd.store)
        begin
            unique case (cmd.sel)
                SEL_Y:   fy_reg <= f_val;
                SEL_Z:   fz_reg <= f_val;
                default: fx_reg <= f_val;
            endcase
        end
        if (cmd.out_load)
        begin
            x_min_reg <= x_reg;
            f_min_reg <= fx_reg;
            steps_reg <= k_reg;
            cap_reg   <= len_gt_tol;
        end
    end

    assign x_min       = x_min_reg;
    assign f_min       = f_min_reg;
    assign steps_taken = steps_reg;
    assign cap_reached = cap_reg;

endmodule

// File: design/ihm_ctrl.sv
`timescale 1ns / 1ps
// ihm_ctrl: sequencer for the halving passes and the output handshake
module ihm_ctrl
    import ihm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ihm_stat_t stat,
    output ihm_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQ     = 3'd1;
    localparam logic [2:0] ST_CU     = 3'd2;
    localparam logic [2:0] ST_FIN    = 3'd3;
    localparam logic [2:0] ST_CHECK  = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    sel_t       sel_reg;
    sel_t       sel_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.sel        = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    sel_next   = SEL_X;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.mul_sq = 1'b1;
                state_next = ST_CU;
            end
            ST_CU:
            begin
                cmd.mul_cu = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.store = 1'b1;
                unique case (sel_reg)
                    SEL_Y:
                    begin
                        sel_next   = SEL_Z;
                        state_next = ST_SQ;
                    end
                    SEL_Z:   state_next = ST_UPDATE;
                    default: state_next = ST_CHECK;
                endcase
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.more)
                begin
                    sel_next   = SEL_Y;
                    state_next = ST_SQ;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/interval_halving_minimizer_core.sv
`timescale 1ns / 1ps
// interval_halving_minimizer_core: top level of the cubic minimum search
// One item at a time: a search runs N halving passes (N at most MAX_STEPS). Each pass makes
// two cubic evaluations, each a square, a cube and a store step, on the one shared 24x20
// multiplier, plus an update and a stop check.
// A new item is taken as soon as the search has handed its item to the output register,
// so the next search runs while the previous item waits on the result channel.
// Tolerance writes are taken every cycle and count from the next stop check on, including
// one of a search in flight, so they belong between searches.
module interval_halving_minimizer_core
    import ihm_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    ihm_in_if.sink    operands,
    ihm_out_if.source result,
    ihm_cfg_if.sink   cfg
);

    ihm_cmd_t  cmd;
    ihm_stat_t stat;

    assign cfg.ready = 1'b1;

    ihm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operands.valid),
        .in_ready  (operands.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ihm_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .left_end      (operands.left_end),
        .right_end     (operands.right_end),
        .cfg_valid     (cfg.valid),
        .cfg_tolerance (cfg.tolerance),
        .x_min         (result.x_min),
        .f_min         (result.f_min),
        .steps_taken   (result.steps_taken),
        .cap_reached   (result.cap_reached)
    );

endmodule

// File: tb/ihm_search_checker.sv
`timescale 1ns / 1ps
// ihm_search_checker: watches the search channels, predicts each result and compares it
module ihm_search_checker
    import ihm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ihm_in_if    operands,
    ihm_out_if   result,
    ihm_cfg_if   cfg,
    output int   mismatches,
    output int   pending
);

    typedef struct packed {
        coord_t x_min;
        fval_t  f_min;
        step_t  steps_taken;
        logic   cap_reached;
    } search_result_t;

    search_result_t expected_results[$];
    tol_t           tol_now;
    int             fail_total = 0;

    task automatic report_mismatch(input string msg);
        if (fail_total < 100)
            $display("%0t ns: mismatch: %s", $time, msg);
        fail_total++;
    endtask

    // f(x) = x^3 + 3x^2 - 2 in Q16.16, products floored, saturated to 32 bits
    function automatic fval_t cubic_q16(input longint x);
        longint sq;
        longint cu;
        longint sum;
        sq = (x * x) >>> FRAC_BITS;
        cu = (sq * x) >>> FRAC_BITS;
        sum = cu + 3 * sq - (longint'(2) <<< FRAC_BITS);
        if (sum > 64'sd2147483647)
            sum = 64'sd2147483647;
        else if (sum < -64'sd2147483648)
            sum = -64'sd2147483648;
        return fval_t'(sum);
    endfunction

    function automatic search_result_t predict_search(input coord_t left, input coord_t right,
                                                      input tol_t tol);
        longint lo;
        longint hi;
        longint x;
        longint span;
        longint quarter;
        longint y;
        longint z;
        longint swap_tmp;
        fval_t  fx;
        fval_t  fy;
        fval_t  fz;
        int     passes;
        search_result_t r;
        lo = left;
        hi = right;
        if (lo > hi)
        begin
            swap_tmp = lo;
            lo = hi;
            hi = swap_tmp;
        end
        x = (lo + hi) >>> 1;
        fx = cubic_q16(x);
        span = hi - lo;
        passes = 0;
        while (span > longint'(tol) && passes < MAX_STEPS_DEF)
        begin
            quarter = span >>> 2;
            y = lo + quarter;
            z = hi - quarter;
            fy = cubic_q16(y);
            fz = cubic_q16(z);
            if (fy < fx)
            begin
                hi = x;
                x = y;
                fx = fy;
            end
            else if (fz < fx)
            begin
                lo = x;
                x = z;
                fx = fz;
            end
            else
            begin
                lo = y;
                hi = z;
            end
            span = hi - lo;
            passes++;
        end
        r.x_min = coord_t'(x);
        r.f_min = fx;
        r.steps_taken = step_t'(passes);
        r.cap_reached = (span > longint'(tol));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        search_result_t want;
        if (!rst_n)
        begin
            tol_now = TOL_RESET;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                tol_now = cfg.tolerance;
            if (operands.valid && operands.ready)
                expected_results.push_back(predict_search(operands.left_end,
                                                          operands.right_end, tol_now));
            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result with none expected: x_min %0d f_min %0d",
                                              result.x_min, result.f_min));
                else
                begin
                    want = expected_results.pop_front();
                    if (result.x_min !== want.x_min)
                        report_mismatch($sformatf("x_min got %0d expected %0d",
                                                  result.x_min, want.x_min));
                    if (result.f_min !== want.f_min)
                        report_mismatch($sformatf("f_min got %0d expected %0d",
                                                  result.f_min, want.f_min));
                    if (result.steps_taken !== want.steps_taken)
                        report_mismatch($sformatf("steps_taken got %0d expected %0d",
                                                  result.steps_taken, want.steps_taken));
                    if (result.cap_reached !== want.cap_reached)
                        report_mismatch($sformatf("cap_reached got %0b expected %0b",
                                                  result.cap_reached, want.cap_reached));
                end
            end
            pending <= expected_results.size();
        end
        mismatches <= fail_total;
    end

endmodule

// File: tb/interval_halving_minimizer_core_test.sv
`timescale 1ns / 1ps
// interval_halving_minimizer_core_test: stimulus, idling and verdict for the minimum search core
module interval_halving_minimizer_core_test
    import ihm_pkg::*;
();

    localparam int ITEMS_PER_PHASE = 200;
    localparam int NUM_PHASES      = 8;
    localparam int LONG_HOLD       = 2000;
    localparam int DRAIN_CYCLES    = 500;
    localparam coord_t COORD_MIN   = coord_t'(-524288);
    localparam coord_t COORD_MAX   = coord_t'(524287);
    localparam coord_t ONE_Q16     = coord_t'(65536);

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_seq;

    ihm_in_if  operands_if();
    ihm_out_if result_if();
    ihm_cfg_if cfg_if();

    interval_halving_minimizer_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands_if),
        .result   (result_if),
        .cfg      (cfg_if)
    );

    ihm_search_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .operands   (operands_if),
        .result     (result_if),
        .cfg        (cfg_if),
        .mismatches (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_seen;
        hold_seen = 0;
        result_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_seq)
            begin
                hold_seen = hold_seq;
                result_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input coord_t left, input coord_t right);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            operands_if.valid <= 1'b0;
            @(posedge clk);
        end
        operands_if.valid <= 1'b1;
        operands_if.left_end <= left;
        operands_if.right_end <= right;
        do @(posedge clk); while (!operands_if.ready);
    endtask

    task automatic write_tolerance(input tol_t value);
        cfg_if.valid <= 1'b1;
        cfg_if.tolerance <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain_results();
        operands_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_random_item();
        coord_t a;
        coord_t b;
        a = coord_t'($urandom);
        b = coord_t'($urandom);
        case ($urandom_range(9))
            5, 6: b = a + coord_t'($urandom_range(4096));
            7: b = a;
            8:
            begin
                // around the local max at -2 and local min at 0
                a = coord_t'($urandom_range(393215)) - coord_t'(262144);
                b = coord_t'($urandom_range(393215)) - coord_t'(262144);
            end
            9: b = a - coord_t'($urandom_range(300));
            default: ;
        endcase
        send_item(a, b);
    endtask

    function automatic tol_t phase_tolerance(input int phase);
        case (phase)
            0: return tol_t'(1048576);
            1: return tol_t'(1);
            2: return TOL_RESET;
            4: return tol_t'($urandom_range(255, 1));
            5: return tol_t'($urandom_range(1048576, 256));
            default: return tol_t'($urandom_range(1048576, 1));
        endcase
    endfunction

    initial
    begin
        int p;
        operands_if.valid = 1'b0;
        operands_if.left_end = '0;
        operands_if.right_end = '0;
        cfg_if.valid = 1'b0;
        cfg_if.tolerance = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_seq = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at the reset tolerance
        send_item(COORD_MIN, COORD_MAX);
        send_item(COORD_MAX, COORD_MIN);
        send_item(coord_t'(0), coord_t'(0));
        send_item(COORD_MIN, COORD_MIN);
        send_item(COORD_MAX, COORD_MAX);
        send_item(coord_t'(0), coord_t'(66));
        send_item(coord_t'(0), coord_t'(67));
        send_item(coord_t'(-1), coord_t'(1));
        send_item(COORD_MIN, COORD_MIN + coord_t'(1));
        send_item(COORD_MAX - coord_t'(1), COORD_MAX);
        send_item(-coord_t'(2) * ONE_Q16, coord_t'(0));
        send_item(-ONE_Q16, ONE_Q16);
        send_item(coord_t'(0), COORD_MAX);
        send_item(COORD_MIN, coord_t'(0));
        send_item(-coord_t'(3) * ONE_Q16, -ONE_Q16);
        send_item(coord_t'(1), coord_t'(-1));
        send_item(ONE_Q16, COORD_MIN);

        // tiny tolerance: the quarter step can reach zero and the cap ends the search
        drain_results();
        write_tolerance(tol_t'(1));
        send_item(COORD_MIN, COORD_MAX);
        send_item(-ONE_Q16, ONE_Q16);
        send_item(coord_t'(5), coord_t'(9));
        send_item(coord_t'(0), coord_t'(3));

        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            write_tolerance(phase_tolerance(p));
            case (p % 4)
                1:
                begin
                    send_idle_pct = 86;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 86;
                end
                3:
                begin
                    send_idle_pct = 19;
                    recv_stall_pct <= 19;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
            endcase
            if (p == 4)
                hold_seq <= hold_seq + 1;
            repeat (ITEMS_PER_PHASE) send_random_item();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
